/* rtl/sjsm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sjsm_pkg: shared types and constants
// Widths, register indexes and the sequencer state encoding for the block.
// ----------------------------------------------------------------------------
package sjsm_pkg;

  localparam int unsigned MaxPoints   = 1024;
  localparam int unsigned MaxClusters = 32;
  localparam int unsigned CoordBits   = 16;
  localparam int unsigned IdxW        = $clog2(MaxPoints);
  localparam int unsigned LenW        = IdxW + 1;
  localparam int unsigned CidW        = $clog2(MaxClusters);
  localparam int unsigned CntW        = CidW + 1;
  localparam int unsigned SumW        = CoordBits + LenW;
  localparam int unsigned ThrW        = 20;
  localparam int unsigned DiffW       = CoordBits + 1;
  localparam int unsigned D2W         = 2 * DiffW + 1;
  localparam int unsigned LimW        = 2 * ThrW;

  localparam logic [0:0] RegThreshold = 1'b0;
  localparam logic [0:0] RegMinLen    = 1'b1;

  localparam logic [ThrW-1:0] ThrReset    = 20'd10000;
  localparam logic [LenW-1:0] MinLenReset = 11'd3;

  typedef struct packed {
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
  } point_t;

  typedef enum logic [8:0] {
    StIdle  = 9'b0_0000_0001,
    StGap   = 9'b0_0000_0010,
    StJmp   = 9'b0_0000_0100,
    StFin   = 9'b0_0000_1000,
    StDivX  = 9'b0_0001_0000,
    StDivY  = 9'b0_0010_0000,
    StRead  = 9'b0_0100_0000,
    StTest  = 9'b0_1000_0000,
    StOut   = 9'b1_0000_0000
  } state_e;

endpackage
`default_nettype wire

/* rtl/scan_jump_segment_merge.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scan_jump_segment_merge: range-scan segmentation with cluster merging
// Splits a point stream at jumps, keeps long segments and merges them into a
// 32-entry cluster table.
// ----------------------------------------------------------------------------
// One point at a time. A point that continues its segment goes through accept,
// gap through the shared squared-distance unit, break decision and bookkeeping.
// A point that closes a kept segment adds two centroid divisions on the serial
// divider, a table walk (per entry visited, one registered table read, then
// five distance tests on the one distance unit, each checked in the cycle
// after its pair is selected) and loading the output register. The block is
// not ready while an item is in work; a result waits in the output register
// and only a stalled output holds the sequencer.
module scan_jump_segment_merge (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,  // point_x, point_y
  input  wire logic         s_axis_tlast,  // scan_end
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [63:0]       m_axis_tdata,  // seg_start, seg_length, cluster_id,
                                           // merged, table_full, cog_x, cog_y
  output logic              m_axis_tlast,  // scan_done
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [0:0]   cfg_index_i,
  input  wire logic [19:0]  cfg_data_i
);

  localparam int unsigned NC = sjsm_pkg::MaxClusters;
  localparam logic [2:0] PhLast = 3'd5;

  sjsm_pkg::state_e st_q;
  logic [sjsm_pkg::ThrW-1:0] thr_q;
  logic [sjsm_pkg::LenW-1:0] minlen_q;
  logic [sjsm_pkg::LimW-1:0] lim_q;
  logic [sjsm_pkg::IdxW-1:0] pidx_q, sstart_q, cstart_q;
  logic [sjsm_pkg::LenW-1:0] len_q, clen_q;
  sjsm_pkg::point_t prev_q, first_q, cfirst_q, clast_q, cog_q, p_q;
  logic signed [sjsm_pkg::SumW-1:0] sx_q, sy_q, csx_q, csy_q;
  logic end_q, done_q;
  logic [sjsm_pkg::CntW-1:0] ccnt_q;
  logic [sjsm_pkg::CidW-1:0] ci_q;
  logic [2:0] ph_q;
  logic hit_q, started_q, dn_q;

  sjsm_pkg::point_t fr_mem [NC], bk_mem [NC], cg_mem [NC];
  sjsm_pkg::point_t fr_rd_q, bk_rd_q, cg_rd_q;

  logic o_valid_q;
  logic [sjsm_pkg::IdxW-1:0] o_start_q;
  logic [sjsm_pkg::LenW-1:0] o_len_q;
  logic [sjsm_pkg::CidW-1:0] o_id_q;
  logic o_mrg_q, o_full_q, o_last_q;
  sjsm_pkg::point_t o_cog_q;

  sjsm_pkg::point_t da, db;
  logic [sjsm_pkg::D2W-1:0] d2;
  logic div_start, div_done;
  logic signed [sjsm_pkg::SumW-1:0] div_num;
  logic signed [sjsm_pkg::CoordBits-1:0] quot;
  logic in_acc, gap_brk, keep, d2_hit, tbl_full, out_free;

  assign s_axis_tready = (st_q == sjsm_pkg::StIdle);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  // operand select for the shared distance unit
  always_comb begin
    da = cg_rd_q; db = cog_q;
    if (st_q == sjsm_pkg::StGap) begin
      da = prev_q; db = p_q;
    end else begin
      case (ph_q)
        3'd0: begin da = fr_rd_q; db = cfirst_q; end
        3'd1: begin da = fr_rd_q; db = clast_q; end
        3'd2: begin da = bk_rd_q; db = cfirst_q; end
        3'd3: begin da = bk_rd_q; db = clast_q; end
        default: begin da = cg_rd_q; db = cog_q; end
      endcase
    end
  end

  sjsm_d2 u_d2 (.clk_i(clk_i), .a_i(da), .b_i(db), .d2_o(d2));

  assign div_num = (st_q == sjsm_pkg::StDivX) ? csx_q : csy_q;
  sjsm_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .dividend_i(div_num), .divisor_i(clen_q), .done_o(div_done), .quot_o(quot));

  assign div_start = ((st_q == sjsm_pkg::StDivX) || (st_q == sjsm_pkg::StDivY)) && !started_q;
  assign gap_brk = (d2 > sjsm_pkg::D2W'(thr_q)) ||
                   (len_q >= sjsm_pkg::LenW'(sjsm_pkg::MaxPoints));
  assign keep = (len_q >= minlen_q) && (len_q != '0);
  assign d2_hit = sjsm_pkg::LimW'(d2) < lim_q;
  assign tbl_full = (ccnt_q == sjsm_pkg::CntW'(NC));
  assign out_free = !o_valid_q || m_axis_tready;

  // configuration registers, squared threshold kept alongside
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= sjsm_pkg::ThrReset;
      minlen_q <= sjsm_pkg::MinLenReset;
      lim_q    <= sjsm_pkg::LimW'(sjsm_pkg::ThrReset) * sjsm_pkg::LimW'(sjsm_pkg::ThrReset);
    end else begin
      lim_q <= thr_q * thr_q;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          sjsm_pkg::RegThreshold: thr_q <= cfg_data_i;
          sjsm_pkg::RegMinLen:    minlen_q <= cfg_data_i[sjsm_pkg::LenW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dn_q <= 1'b0;
    end else begin
      dn_q <= div_done;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= sjsm_pkg::StIdle;
      pidx_q    <= '0;
      sstart_q  <= '0;
      cstart_q  <= '0;
      len_q     <= '0;
      clen_q    <= '0;
      prev_q    <= '0;
      first_q   <= '0;
      cfirst_q  <= '0;
      clast_q   <= '0;
      cog_q     <= '0;
      p_q       <= '0;
      sx_q      <= '0;
      sy_q      <= '0;
      csx_q     <= '0;
      csy_q     <= '0;
      end_q     <= 1'b0;
      done_q    <= 1'b0;
      ccnt_q    <= '0;
      ci_q      <= '0;
      ph_q      <= '0;
      hit_q     <= 1'b0;
      started_q <= 1'b0;
    end else begin
      case (st_q)
        sjsm_pkg::StIdle: begin
          if (in_acc) begin
            p_q.x  <= s_axis_tdata[15:0];
            p_q.y  <= s_axis_tdata[31:16];
            end_q  <= s_axis_tlast;
            done_q <= 1'b0;
            st_q   <= sjsm_pkg::StGap;
          end
        end
        sjsm_pkg::StGap: begin
          st_q <= sjsm_pkg::StJmp;
        end
        sjsm_pkg::StJmp: begin
          if (len_q == '0 || gap_brk) begin
            if (len_q != '0) begin
              cstart_q <= sstart_q;
              clen_q   <= len_q;
              cfirst_q <= first_q;
              clast_q  <= prev_q;
              csx_q    <= sx_q;
              csy_q    <= sy_q;
            end
            sstart_q <= pidx_q;
            first_q  <= p_q;
            prev_q   <= p_q;
            sx_q     <= sjsm_pkg::SumW'($signed(p_q.x));
            sy_q     <= sjsm_pkg::SumW'($signed(p_q.y));
            len_q    <= sjsm_pkg::LenW'(1);
            st_q     <= (len_q != '0 && keep) ? sjsm_pkg::StDivX : sjsm_pkg::StFin;
          end else begin
            sx_q   <= sx_q + sjsm_pkg::SumW'($signed(p_q.x));
            sy_q   <= sy_q + sjsm_pkg::SumW'($signed(p_q.y));
            len_q  <= len_q + sjsm_pkg::LenW'(1);
            prev_q <= p_q;
            st_q   <= sjsm_pkg::StFin;
          end
        end
        sjsm_pkg::StFin: begin
          if (end_q && !done_q && len_q >= sjsm_pkg::LenW'(2)) begin
            // scan end closes the open segment with this point as its last
            cstart_q <= sstart_q;
            clen_q   <= len_q;
            cfirst_q <= first_q;
            clast_q  <= p_q;
            csx_q    <= sx_q;
            csy_q    <= sy_q;
            done_q   <= 1'b1;
            if (keep) st_q <= sjsm_pkg::StDivX;
          end else begin
            if (end_q) begin
              pidx_q   <= '0;
              sstart_q <= '0;
              prev_q   <= '0;
              first_q  <= '0;
              sx_q     <= '0;
              sy_q     <= '0;
              len_q    <= '0;
              ccnt_q   <= '0;
            end else begin
              pidx_q <= pidx_q + sjsm_pkg::IdxW'(1);
            end
            st_q <= sjsm_pkg::StIdle;
          end
        end
        sjsm_pkg::StDivX: begin
          if (div_start) started_q <= 1'b1;
          if (dn_q) begin
            cog_q.x   <= quot;
            started_q <= 1'b0;
            st_q      <= sjsm_pkg::StDivY;
          end
        end
        sjsm_pkg::StDivY: begin
          if (div_start) started_q <= 1'b1;
          if (dn_q) begin
            cog_q.y   <= quot;
            started_q <= 1'b0;
            ci_q      <= '0;
            hit_q     <= 1'b0;
            st_q      <= (ccnt_q == '0) ? sjsm_pkg::StOut : sjsm_pkg::StRead;
          end
        end
        sjsm_pkg::StRead: begin
          ph_q <= '0;
          st_q <= sjsm_pkg::StTest;
        end
        sjsm_pkg::StTest: begin
          // distance of the previous phase's pair is checked here
          if (ph_q != 3'd0 && d2_hit) begin
            hit_q <= 1'b1;
            st_q  <= sjsm_pkg::StOut;
          end else if (ph_q == PhLast) begin
            if ({1'b0, ci_q} + sjsm_pkg::CntW'(1) == ccnt_q) begin
              st_q <= sjsm_pkg::StOut;
            end else begin
              ci_q <= ci_q + sjsm_pkg::CidW'(1);
              st_q <= sjsm_pkg::StRead;
            end
          end else begin
            ph_q <= ph_q + 3'd1;
          end
        end
        sjsm_pkg::StOut: begin
          if (out_free) begin
            if (!hit_q && !tbl_full) ccnt_q <= ccnt_q + sjsm_pkg::CntW'(1);
            st_q <= sjsm_pkg::StFin;
          end
        end
        default: st_q <= sjsm_pkg::StIdle;
      endcase
    end
  end

  // cluster table
  always_ff @(posedge clk_i) begin
    fr_rd_q <= fr_mem[ci_q];
    bk_rd_q <= bk_mem[ci_q];
    cg_rd_q <= cg_mem[ci_q];
    if (st_q == sjsm_pkg::StOut && out_free) begin
      if (hit_q) begin
        bk_mem[ci_q] <= cfirst_q;
      end else if (!tbl_full) begin
        fr_mem[ccnt_q[sjsm_pkg::CidW-1:0]] <= cfirst_q;
        bk_mem[ccnt_q[sjsm_pkg::CidW-1:0]] <= clast_q;
        cg_mem[ccnt_q[sjsm_pkg::CidW-1:0]] <= cog_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      o_start_q <= '0;
      o_len_q   <= '0;
      o_id_q    <= '0;
      o_mrg_q   <= 1'b0;
      o_full_q  <= 1'b0;
      o_last_q  <= 1'b0;
      o_cog_q   <= '0;
    end else if (st_q == sjsm_pkg::StOut && out_free) begin
      o_valid_q <= 1'b1;
      o_start_q <= cstart_q;
      o_len_q   <= clen_q;
      o_id_q    <= hit_q ? ci_q :
                   (tbl_full ? '0 : ccnt_q[sjsm_pkg::CidW-1:0]);
      o_mrg_q   <= hit_q;
      o_full_q  <= !hit_q && tbl_full;
      o_last_q  <= end_q;
      o_cog_q   <= cog_q;
    end else if (m_axis_tready) begin
      o_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = {4'b0, o_cog_q.y, o_cog_q.x, o_full_q, o_mrg_q, o_id_q,
                          o_len_q, o_start_q};
  assign m_axis_tlast  = o_last_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(st_q)) else $error("sequencer state not one-hot");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result item changed while waiting");
  a_ccnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ccnt_q <= sjsm_pkg::CntW'(NC)) else $error("cluster count out of range");
  a_accept_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> st_q == sjsm_pkg::StGap) else $error("accepted item not started");

endmodule
`default_nettype wire

/* rtl/sjsm_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sjsm_div: restoring divider
// Signed sum divided by an unsigned length, truncating toward zero, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module sjsm_div (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic signed [sjsm_pkg::SumW-1:0]   dividend_i,
  input  wire logic        [sjsm_pkg::LenW-1:0]   divisor_i,
  output logic                                    done_o,
  output logic signed [sjsm_pkg::CoordBits-1:0]   quot_o
);

  localparam int unsigned SW = sjsm_pkg::SumW;
  localparam int unsigned CW = $clog2(SW + 1);

  logic [SW-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [sjsm_pkg::LenW-1:0] den_q;
  logic neg_q, busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [SW:0] trial;
  logic [SW-1:0] mag, qs;

  assign mag = dividend_i[SW-1] ? SW'(-dividend_i) : SW'(dividend_i);

  always_comb begin
    trial  = {rem_q, quo_q[SW-1]};
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d = '0; quo_d = mag; cnt_d = CW'(SW); busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[SW-2:0], 1'b0};
      if (trial >= (SW+1)'(den_q)) begin
        rem_d = SW'(trial - (SW+1)'(den_q));
        quo_d[0] = 1'b1;
      end else begin
        rem_d = SW'(trial);
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= divisor_i;
      neg_q <= dividend_i[SW-1];
    end
  end

  assign qs     = neg_q ? SW'(-quo_q) : quo_q;
  assign quot_o = qs[sjsm_pkg::CoordBits-1:0];
  assign done_o = busy_q && (cnt_q == CW'(1));

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_q) else $error("divider still busy after done");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("divider not started");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0) else $error("divider count underflow");

endmodule
`default_nettype wire

/* rtl/sjsm_d2.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sjsm_d2: squared distance unit
// Shared squared XY distance between two points, summed from registered squares.
// ----------------------------------------------------------------------------
module sjsm_d2 (
  input  wire logic                         clk_i,
  input  wire sjsm_pkg::point_t             a_i,
  input  wire sjsm_pkg::point_t             b_i,
  output logic [sjsm_pkg::D2W-1:0]          d2_o
);

  localparam int unsigned DW = sjsm_pkg::DiffW;

  logic signed [DW-1:0] dx, dy;
  logic [2*DW-1:0] sx_q, sy_q;

  assign dx = DW'(a_i.x) - DW'(b_i.x);
  assign dy = DW'(a_i.y) - DW'(b_i.y);

  always_ff @(posedge clk_i) begin
    sx_q <= (2*DW)'(dx * dx);
    sy_q <= (2*DW)'(dy * dy);
  end

  assign d2_o = sjsm_pkg::D2W'(sx_q) + sjsm_pkg::D2W'(sy_q);

endmodule
`default_nettype wire
